/* sv/closed_cardinal_spline_eval_unit_assert.svh */
// Assertion macros for the closed cardinal spline evaluator.
// Used by the top level only; define NO_ASSERTIONS to drop them.
`ifndef CLOSED_CARDINAL_SPLINE_EVAL_UNIT_ASSERT_SVH
`define CLOSED_CARDINAL_SPLINE_EVAL_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define CCS_ASSERT_IMPL(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
      else $error("assertion failed");
`define CCS_ASSERT_NEXT(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
      else $error("assertion failed");
`else
`define CCS_ASSERT_IMPL(label, clk, rst, a, c)
`define CCS_ASSERT_NEXT(label, clk, rst, a, c)
`endif
`endif

/* sv/ccs_pkg.sv */
// Shared types and constants for the closed cardinal spline evaluator.
// No dependencies.
package ccs_pkg;
   localparam int MaxPoints = 64;
   localparam int IdxW = $clog2(MaxPoints);
   localparam int FracBits = 16;
   localparam logic [16:0] TensionOne = 17'd65536;

   typedef enum logic [1:0] {
      CSR_TENSION = 2'd0,
      CSR_COUNT   = 2'd1
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_MOD, ST_U2, ST_U3, ST_WGT, ST_FETCH, ST_MAC, ST_OUT
   } state_type;

   // control between sequencer and multiply-accumulate datapath
   typedef struct packed {
      logic        clr;      // clear accumulator
      logic        mac;      // accumulate product
      logic [63:0] opa;
      logic [63:0] opb;
   } mac_ctl_type;

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      if (v > 64'sd2147483647) return 32'sh7fffffff;
      else if (v < -64'sd2147483648) return 32'sh80000000;
      else return v[31:0];
   endfunction
endpackage

/* sv/ccs_mac.sv */
// Shared multiply-accumulate unit, 64-bit accumulator, one product per cycle.
// Depends on ccs_pkg.
module ccs_mac import ccs_pkg::*; (
   input  logic              clock,
   input  mac_ctl_type       ctl,
   output logic signed [63:0] prod,
   output logic signed [63:0] acc
);
   logic signed [63:0] prod_ff, acc_ff, acc_in;
   logic               mac_ff, clr_ff;
   always_ff @(posedge clock) begin
      // operands are at most 33 by 33 significant bits
      prod_ff <= $signed(ctl.opa[32:0]) * $signed(ctl.opb[32:0]);
      mac_ff  <= ctl.mac;
      clr_ff  <= ctl.clr;
      acc_ff  <= acc_in;
   end
   always_comb begin
      acc_in = acc_ff;
      if (clr_ff) acc_in = 64'sd0;
      if (mac_ff) acc_in = (clr_ff ? 64'sd0 : acc_ff) + prod_ff;
   end
   assign prod = prod_ff;
   assign acc  = acc_ff;
endmodule

/* sv/ccs_point_ram.sv */
// Control point memory, one 96-bit word per slot, registered read.
// Depends on ccs_pkg.
module ccs_point_ram import ccs_pkg::*; (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [IdxW-1:0]   wr_addr,
   input  logic [95:0]       wr_data,
   input  logic [IdxW-1:0]   rd_addr,
   output logic [95:0]       rd_data
);
   logic [95:0] mem [MaxPoints];
   logic [95:0] rd_ff;
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_ff <= mem[rd_addr];
   end
   assign rd_data = rd_ff;
endmodule

/* sv/closed_cardinal_spline_eval_unit.sv */
// Closed cardinal spline evaluator, top level; results cannot be stalled.
// Write items do not raise busy. An evaluate item keeps busy high through a
// 39-step restoring modulo, u^2 and u^3, weight setup, the point fetch and
// 24 shared multiply-accumulate passes; the result strobes in the cycle busy
// drops, and a new item is accepted only while busy is low.
// Synchronous active-high reset restores control and CSR registers; points stay undefined.
`include "closed_cardinal_spline_eval_unit_assert.svh"
module closed_cardinal_spline_eval_unit import ccs_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic               req_mode,
   input  logic [5:0]         req_point_index,
   input  logic signed [31:0] req_coord_x,
   input  logic signed [31:0] req_coord_y,
   input  logic signed [31:0] req_coord_z,
   input  logic [31:0]        req_param_t,
   output logic               rsp_strobe,
   output logic signed [31:0] rsp_pos_x,
   output logic signed [31:0] rsp_pos_y,
   output logic signed [31:0] rsp_pos_z,
   output logic signed [31:0] rsp_tan_x,
   output logic signed [31:0] rsp_tan_y,
   output logic signed [31:0] rsp_tan_z,
   input  logic               csr_wr_en,
   input  logic [1:0]         csr_index,
   input  logic [16:0]        csr_wdata
);
   state_type state_ff, state_in;
   logic [16:0] tension_ff;
   logic [6:0]  count_ff;
   logic [6:0]  cnt_ff, cnt_in;
   logic [38:0] rem_ff, rem_in;       // remainder of t modulo span
   logic [5:0]  seg_ff, seg_in;
   logic [16:0] u_ff, u2_ff, u3_ff;
   logic signed [63:0] w_ff [8];      // four position, four derivative weights
   logic signed [31:0] pt_ff [4][3];
   logic signed [31:0] res_ff [6];
   logic               strobe_ff, strobe_in;
   mac_ctl_type        ctl;
   logic signed [63:0] prod, acc;
   logic [95:0]        rd_data;
   logic [IdxW-1:0]    rd_addr;
   logic [6:0]         n;
   logic signed [18:0] s;
   logic [38:0]        span_sh, trial;

   assign n = (count_ff == 7'd0) ? 7'd1 : (count_ff > 7'(MaxPoints) ? 7'(MaxPoints) : count_ff);
   assign s = (tension_ff > TensionOne) ? 19'sd65536 : $signed({2'b0, tension_ff});
   assign busy = (state_ff != ST_IDLE);

   wire accept = start && !busy;

   ccs_point_ram u_ram (
      .clock(clock),
      .wr_en(accept && !req_mode && ({1'b0, req_point_index} < 7'(MaxPoints))),
      .wr_addr(req_point_index[IdxW-1:0]),
      .wr_data({req_coord_z, req_coord_y, req_coord_x}),
      .rd_addr(rd_addr), .rd_data(rd_data));

   ccs_mac u_mac (.clock(clock), .ctl(ctl), .prod(prod), .acc(acc));

   // restoring modulo: compare against span shifted by (38 - step)
   assign span_sh = {16'b0, n, 16'b0} << (6'd38 - cnt_ff[5:0]);
   assign trial   = rem_ff - span_sh;

   // point fetch address: neighbor k = cnt
   always_comb begin
      logic [7:0] a;
      a = {2'b0, seg_ff} + {6'b0, cnt_ff[1:0]} + {1'b0, n} - 8'd1;
      // a single-point loop needs a third wrap
      if (a >= {1'b0, n}) a = a - {1'b0, n};
      if (a >= {1'b0, n}) a = a - {1'b0, n};
      if (a >= {1'b0, n}) a = a - {1'b0, n};
      rd_addr = a[IdxW-1:0];
   end

   // weight term table: each weight is sum of coefficient*power terms
   function automatic logic signed [63:0] rs(input logic signed [63:0] v, input int k);
      logic signed [63:0] w;
      w = v + (64'sd1 <<< (k - 1));
      return w >>> k;
   endfunction

   logic signed [63:0] wcalc [8];
   always_comb begin
      logic signed [63:0] su, su2, su3, sv, one;
      su = $signed({47'b0, u_ff}); su2 = $signed({47'b0, u2_ff});
      su3 = $signed({47'b0, u3_ff}); sv = 64'(s); one = 64'sd65536;
      wcalc[0] = sv * (-su3 + 2*su2 - su);
      wcalc[1] = (131072 - sv) * su3 + (sv - 196608) * su2 + (one <<< 16);
      wcalc[2] = (sv - 131072) * su3 + (196608 - 2*sv) * su2 + sv * su;
      wcalc[3] = sv * (su3 - su2);
      wcalc[4] = sv * (-3*su2 + 4*su - one);
      wcalc[5] = 3*(131072 - sv) * su2 + 2*(sv - 196608) * su;
      wcalc[6] = 3*(sv - 131072) * su2 + 2*(196608 - 2*sv) * su + sv * one;
      wcalc[7] = sv * (3*su2 - 2*su);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE; tension_ff <= 17'd32768; count_ff <= 7'd4;
         strobe_ff <= 1'b0; cnt_ff <= '0;
      end else begin
         state_ff <= state_in; strobe_ff <= strobe_in; cnt_ff <= cnt_in;
         if (csr_wr_en && csr_index == CSR_TENSION) tension_ff <= csr_wdata;
         if (csr_wr_en && csr_index == CSR_COUNT) count_ff <= csr_wdata[6:0];
      end
   end

   always_comb begin
      state_in = state_ff; cnt_in = cnt_ff; strobe_in = 1'b0;
      rem_in = rem_ff; seg_in = seg_ff;
      ctl = '{clr: 1'b0, mac: 1'b0, opa: '0, opb: '0};
      case (state_ff)
         ST_IDLE: if (accept && req_mode) begin
            state_in = ST_MOD; cnt_in = '0; rem_in = {7'b0, req_param_t};
         end
         ST_MOD: begin
            if (!trial[38] && rem_ff >= span_sh) rem_in = trial;
            cnt_in = cnt_ff + 7'd1;
            if (cnt_ff == 7'd38) begin state_in = ST_U2; cnt_in = '0; end
         end
         ST_U2: begin
            ctl.opa = {47'b0, u_ff}; ctl.opb = {47'b0, u_ff};
            cnt_in = cnt_ff + 7'd1;
            if (cnt_ff == 7'd1) begin state_in = ST_U3; cnt_in = '0; end
         end
         ST_U3: begin
            ctl.opa = {47'b0, u2_ff}; ctl.opb = {47'b0, u_ff};
            cnt_in = cnt_ff + 7'd1;
            if (cnt_ff == 7'd1) begin state_in = ST_WGT; cnt_in = '0; end
         end
         ST_WGT: begin state_in = ST_FETCH; cnt_in = '0; end
         ST_FETCH: begin
            cnt_in = cnt_ff + 7'd1;
            if (cnt_ff == 7'd4) begin state_in = ST_MAC; cnt_in = '0; end
         end
         ST_MAC: begin
            // cnt[4:2] = output index, cnt[1:0] = neighbor
            ctl.clr = (cnt_ff[1:0] == 2'd0) && cnt_ff < 7'd24;
            ctl.mac = cnt_ff < 7'd24;
            ctl.opa = w_ff[{cnt_ff[4:2] >= 3'd3, cnt_ff[1:0]}];
            ctl.opb = 64'(pt_ff[cnt_ff[1:0]][cnt_ff[4:2] >= 3'd3 ?
                      2'(cnt_ff[4:2] - 3'd3) : cnt_ff[3:2]]);
            cnt_in = cnt_ff + 7'd1;
            if (cnt_ff == 7'd26) begin state_in = ST_OUT; end
         end
         ST_OUT: begin state_in = ST_IDLE; strobe_in = 1'b1; cnt_in = '0; end
         default: state_in = ST_IDLE;
      endcase
      if (state_ff == ST_MOD && cnt_ff == 7'd38) seg_in = rem_in[21:16];
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in; seg_ff <= seg_in;
      if (state_ff == ST_MOD && cnt_ff == 7'd38) u_ff <= {1'b0, rem_in[15:0]};
      if (state_ff == ST_U2 && cnt_ff == 7'd1) u2_ff <= 17'(rs(prod, FracBits));
      if (state_ff == ST_U3 && cnt_ff == 7'd1) u3_ff <= 17'(rs(prod, FracBits));
      if (state_ff == ST_WGT)
         for (int k = 0; k < 8; k++) w_ff[k] <= rs(wcalc[k], 16);
      if (state_ff == ST_FETCH && cnt_ff >= 7'd1) begin
         pt_ff[cnt_ff[1:0] - 2'd1][0] <= rd_data[31:0];
         pt_ff[cnt_ff[1:0] - 2'd1][1] <= rd_data[63:32];
         pt_ff[cnt_ff[1:0] - 2'd1][2] <= rd_data[95:64];
      end
      // accumulator holds a finished sum once the last product has passed the product and accumulator registers
      if (state_ff == ST_MAC && cnt_ff >= 7'd5 && cnt_ff[1:0] == 2'd1)
         res_ff[3'(cnt_ff[4:2]) - 3'd1] <= sat32(rs(acc, FracBits));
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_pos_x = res_ff[0];
   assign rsp_pos_y = res_ff[1];
   assign rsp_pos_z = res_ff[2];
   assign rsp_tan_x = res_ff[3];
   assign rsp_tan_y = res_ff[4];
   assign rsp_tan_z = res_ff[5];

   `CCS_ASSERT_NEXT(a_strobe_one, clock, reset, rsp_strobe, !rsp_strobe)
   `CCS_ASSERT_IMPL(a_strobe_busy, clock, reset, rsp_strobe, !(state_ff == ST_MAC))
   `CCS_ASSERT_NEXT(a_write_idle, clock, reset, accept && !req_mode, !busy)
endmodule

/* tb/sv/closed_cardinal_spline_eval_unit_tb.sv */
// Self-checking testbench for closed_cardinal_spline_eval_unit.
// Needs ccs_pkg and the top level; predicts position and tangent in Q16.16
// and checks every strobed result in order against the predicted samples.
module closed_cardinal_spline_eval_unit_tb;
   import ccs_pkg::*;

   typedef struct {
      logic               mode;
      logic [5:0]         index;
      logic signed [31:0] x, y, z;
      logic [31:0]        t;
   } spline_cmd_type;

   typedef struct {
      logic signed [31:0] px, py, pz, tx, ty, tz;
   } curve_sample_type;

   localparam longint One = 64'sd65536;
   localparam int CycleLimit = 1000000;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic               req_mode = 1'b0;
   logic [5:0]         req_point_index = '0;
   logic signed [31:0] req_coord_x = '0, req_coord_y = '0, req_coord_z = '0;
   logic [31:0]        req_param_t = '0;
   logic               rsp_strobe;
   logic signed [31:0] rsp_pos_x, rsp_pos_y, rsp_pos_z;
   logic signed [31:0] rsp_tan_x, rsp_tan_y, rsp_tan_z;
   logic               csr_wr_en = 1'b0;
   logic [1:0]         csr_index = '0;
   logic [16:0]        csr_wdata = '0;

   closed_cardinal_spline_eval_unit u_dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor state
   logic signed [31:0] pt_x[MaxPoints], pt_y[MaxPoints], pt_z[MaxPoints];
   logic [16:0]        tension_reg = 17'd32768;
   logic [6:0]         count_reg = 7'd4;

   spline_cmd_type   cmd_q[$];
   curve_sample_type sample_q[$];
   spline_cmd_type   cur_cmd;
   bit               quiet = 0;
   int               errors = 0;
   int               cycles = 0;

   function automatic longint round_q(longint v, int k);
      return (v + (64'sd1 <<< (k - 1))) >>> k;
   endfunction

   function automatic logic signed [31:0] blend(ref logic signed [31:0] pts[MaxPoints],
                                                int id[4], longint w[4]);
      longint acc = 0;
      for (int k = 0; k < 4; k++) acc += w[k] * longint'(pts[id[k]]);
      acc = round_q(acc, FracBits);
      if (acc > 64'sd2147483647) return 32'sh7fffffff;
      if (acc < -64'sd2147483648) return 32'sh80000000;
      return acc[31:0];
   endfunction

   function automatic curve_sample_type eval_curve(logic [31:0] t);
      curve_sample_type s;
      longint n, tn, sv, u, u2, u3, two, three, wrapped;
      longint wp[4], wd[4];
      int id[4];
      int seg;
      n = count_reg;
      if (n < 1) n = 1;
      if (n > MaxPoints) n = MaxPoints;
      tn = tension_reg;
      sv = tn > One ? One : tn;
      wrapped = longint'({32'd0, t}) % (n << FracBits);
      seg = int'(wrapped >> FracBits);
      u = wrapped & (One - 1);
      u2 = round_q(u * u, FracBits);
      u3 = round_q(u2 * u, FracBits);
      id[0] = int'((seg + n - 1) % n);
      id[1] = seg;
      id[2] = int'((seg + 1) % n);
      id[3] = int'((seg + 2) % n);
      two = 2 * One;
      three = 3 * One;
      wp[0] = sv * (-u3 + 2 * u2 - u);
      wp[1] = (two - sv) * u3 + (sv - three) * u2 + (One <<< 16);
      wp[2] = (sv - two) * u3 + (three - 2 * sv) * u2 + sv * u;
      wp[3] = sv * (u3 - u2);
      wd[0] = sv * (-3 * u2 + 4 * u - One);
      wd[1] = 3 * (two - sv) * u2 + 2 * (sv - three) * u;
      wd[2] = 3 * (sv - two) * u2 + 2 * (three - 2 * sv) * u + sv * One;
      wd[3] = sv * (3 * u2 - 2 * u);
      for (int k = 0; k < 4; k++) begin
         wp[k] = round_q(wp[k], 16);
         wd[k] = round_q(wd[k], 16);
      end
      s.px = blend(pt_x, id, wp);
      s.py = blend(pt_y, id, wp);
      s.pz = blend(pt_z, id, wp);
      s.tx = blend(pt_x, id, wd);
      s.ty = blend(pt_y, id, wd);
      s.tz = blend(pt_z, id, wd);
      return s;
   endfunction

   task automatic apply_cmd(spline_cmd_type c);
      if (!c.mode) begin
         pt_x[c.index] = c.x;
         pt_y[c.index] = c.y;
         pt_z[c.index] = c.z;
      end else begin
         sample_q.push_back(eval_curve(c.t));
      end
   endtask

   // driver: holds start until the transfer, then maybe idles
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) apply_cmd(cur_cmd);
         if (!(start && busy)) begin
            if (cmd_q.size() > 0 && (quiet || $urandom_range(99) >= 6)) begin
               cur_cmd = cmd_q.pop_front();
               req_mode        <= cur_cmd.mode;
               req_point_index <= cur_cmd.index;
               req_coord_x     <= cur_cmd.x;
               req_coord_y     <= cur_cmd.y;
               req_coord_z     <= cur_cmd.z;
               req_param_t     <= cur_cmd.t;
               start <= 1'b1;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   function automatic void check_field(string name, logic signed [31:0] exp_v,
                                       logic signed [31:0] act_v);
      if (exp_v !== act_v) begin
         $display("%0t: %s mismatch, expected %h actual %h", $time, name, exp_v, act_v);
         errors++;
      end
   endfunction

   // monitor
   always @(posedge clock) begin
      curve_sample_type e;
      if (!reset && rsp_strobe) begin
         if (sample_q.size() == 0) begin
            $display("%0t: unexpected result, expected none actual pos %h %h %h",
                     $time, rsp_pos_x, rsp_pos_y, rsp_pos_z);
            errors++;
         end else begin
            e = sample_q.pop_front();
            check_field("pos_x", e.px, rsp_pos_x);
            check_field("pos_y", e.py, rsp_pos_y);
            check_field("pos_z", e.pz, rsp_pos_z);
            check_field("tan_x", e.tx, rsp_tan_x);
            check_field("tan_y", e.ty, rsp_tan_y);
            check_field("tan_z", e.tz, rsp_tan_z);
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CycleLimit) begin
         $display("Some tests failed");
         $finish;
      end
   end

   function automatic logic signed [31:0] rand_coord();
      case ($urandom_range(3))
         0: return $urandom;
         1: return $signed($urandom_range(32'h7ffff)) - 32'sh40000;
         2: return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
         default: return $signed($urandom_range(32'hffffff)) - 32'sh800000;
      endcase
   endfunction

   function automatic logic [31:0] rand_param();
      logic [31:0] span;
      span = 32'({count_reg, 16'd0});
      if (span == 0) span = 32'h10000;
      case ($urandom_range(4))
         0: return $urandom;
         1: return {16'($urandom_range(127)), $urandom_range(1) ? 16'hffff : 16'h0000};
         default: return $urandom_range(span > 32'h400000 ? 32'h400000 : span);
      endcase
   endfunction

   function automatic void push_point(int idx, logic signed [31:0] x,
                                      logic signed [31:0] y, logic signed [31:0] z);
      spline_cmd_type c;
      c.mode = 1'b0; c.index = idx[5:0]; c.x = x; c.y = y; c.z = z; c.t = $urandom;
      cmd_q.push_back(c);
   endfunction

   function automatic void push_eval(logic [31:0] t);
      spline_cmd_type c;
      c.mode = 1'b1; c.index = 6'($urandom); c.x = $urandom; c.y = $urandom;
      c.z = $urandom;
      c.t = t;
      cmd_q.push_back(c);
   endfunction

   task automatic wait_idle();
      while (cmd_q.size() > 0 || start || sample_q.size() > 0) @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   task automatic write_csr(csr_index_type idx, logic [16:0] val);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      if (idx == CSR_TENSION) tension_reg = val;
      else count_reg = val[6:0];
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   initial begin
      logic [16:0] ten_set[8] = '{17'd32768, 17'd0, 17'd65536, 17'd131071,
                                   17'd16384, 17'd49152, 17'd32768, 17'd65535};
      logic [16:0] cnt_set[8] = '{17'd4, 17'd1, 17'd64, 17'd127,
                                   17'd0, 17'd2, 17'd3, 17'd37};
      for (int i = 0; i < MaxPoints; i++) begin
         pt_x[i] = '0; pt_y[i] = '0; pt_z[i] = '0;
      end
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // fill every slot so no evaluation reads an unwritten entry
      for (int i = 0; i < MaxPoints; i++) push_point(i, rand_coord(), rand_coord(), rand_coord());
      // extremes to drive saturation on all axes
      push_point(0, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff);
      push_point(1, 32'sh80000000, 32'sh7fffffff, 32'sh80000000);
      push_point(2, 32'sh7fffffff, 32'sh80000000, 32'sh00000000);
      push_point(3, 32'sh80000000, 32'sh7fffffff, 32'sh00010000);
      push_point(63, 32'sh7fffffff, 32'sh7fffffff, 32'sh80000000);
      push_eval(32'h0000_0000);
      push_eval(32'h0000_8000);
      push_eval(32'h0000_ffff);
      push_eval(32'h0001_0000);
      push_eval(32'h0003_ffff);
      push_eval(32'h0004_0000);
      push_eval(32'hffff_ffff);
      push_eval(32'h8000_0000);
      push_eval(32'h7fff_ffff);
      push_eval(32'h0002_4000);
      wait_idle();

      for (int ph = 0; ph < 8; ph++) begin
         if (ph > 0) begin
            write_csr(CSR_TENSION, ten_set[ph]);
            write_csr(CSR_COUNT, cnt_set[ph]);
         end
         quiet = (ph == 5);
         if (ph == 1) begin
            push_eval(32'h0);
            push_eval(32'hffff_ffff);
         end
         for (int k = 0; k < 135; k++) begin
            if ($urandom_range(99) < 20)
               push_point($urandom_range(MaxPoints - 1), rand_coord(), rand_coord(),
                          rand_coord());
            else
               push_eval(rand_param());
         end
         wait_idle();
      end

      if (errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end
endmodule

/* closed_cardinal_spline_eval_unit.f */
+incdir+sv
sv/ccs_pkg.sv
sv/ccs_mac.sv
sv/ccs_point_ram.sv
sv/closed_cardinal_spline_eval_unit.sv
tb/sv/closed_cardinal_spline_eval_unit_tb.sv
